[design/lbc_pkg.sv]
package lbc_pkg;

    localparam int KERNEL_SIZE = 5;
    localparam int MAX_WIDTH   = 1024;
    localparam int LINES       = KERNEL_SIZE - 1;

    localparam int PIX_W      = 16;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int ACC_W      = 40;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int COEF_IDX_W = 3;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int HW_W  = COL_W + 1;
    localparam int W_W   = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_COEF  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic signed [PIX_W-1:0]  pix_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef pix_t win_t [KERNEL_SIZE][KERNEL_SIZE];

    typedef struct packed {
        logic last_of_row;
        logic last_of_frame;
    } tag_t;

endpackage

[design/lbc_dot.sv]
module lbc_dot (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lbc_pkg::tag_t     in_tag,
    input  lbc_pkg::win_t     window,
    input  lbc_pkg::win_t     coef,
    output logic              out_valid,
    output lbc_pkg::tag_t     out_tag,
    output lbc_pkg::acc_t     out_value
);

    logic          p_valid_reg;
    lbc_pkg::tag_t p_tag_reg;
    lbc_pkg::prod_t prod_reg [lbc_pkg::KERNEL_SIZE][lbc_pkg::KERNEL_SIZE];

    logic          r_valid_reg;
    lbc_pkg::tag_t r_tag_reg;
    lbc_pkg::acc_t row_reg  [lbc_pkg::KERNEL_SIZE];
    lbc_pkg::acc_t row_next [lbc_pkg::KERNEL_SIZE];

    logic          t_valid_reg;
    lbc_pkg::tag_t t_tag_reg;
    lbc_pkg::acc_t total_reg;
    lbc_pkg::acc_t total_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            r_valid_reg <= p_valid_reg;
            t_valid_reg <= r_valid_reg;
        end
    end

    // one multiplier per tap, then a row sum, then the sum of rows
    always_ff @(posedge clk)
    begin
        for (int m = 0; m < lbc_pkg::KERNEL_SIZE; m++)
        begin
            for (int n = 0; n < lbc_pkg::KERNEL_SIZE; n++)
            begin
                prod_reg[m][n] <= window[m][n] * coef[m][n];
            end
            row_reg[m] <= row_next[m];
        end
        p_tag_reg <= in_tag;
        r_tag_reg <= p_tag_reg;
        t_tag_reg <= r_tag_reg;
        total_reg <= total_next;
    end

    always_comb
    begin
        for (int m = 0; m < lbc_pkg::KERNEL_SIZE; m++)
        begin
            row_next[m] = '0;
            for (int n = 0; n < lbc_pkg::KERNEL_SIZE; n++)
            begin
                row_next[m] = row_next[m] + lbc_pkg::acc_t'(prod_reg[m][n]);
            end
        end
    end

    always_comb
    begin
        total_next = '0;
        for (int m = 0; m < lbc_pkg::KERNEL_SIZE; m++)
        begin
            total_next = total_next + row_reg[m];
        end
    end

    assign out_valid = t_valid_reg;
    assign out_tag   = t_tag_reg;
    assign out_value = total_reg;

endmodule

[design/lbc_ofifo.sv]
module lbc_ofifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lbc_pkg::tag_t push_tag,
    input  lbc_pkg::acc_t push_value,
    output logic          out_valid,
    input  logic          out_stall,
    output lbc_pkg::tag_t out_tag,
    output lbc_pkg::acc_t out_value
);

    lbc_pkg::acc_t value_mem [lbc_pkg::FIFO_DEPTH];
    lbc_pkg::tag_t tag_mem   [lbc_pkg::FIFO_DEPTH];

    logic [lbc_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [lbc_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [lbc_pkg::FIFO_AW:0]   count_reg;
    logic                        pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign out_value = value_mem[rd_ptr_reg];
    assign out_tag   = tag_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            value_mem[wr_ptr_reg] <= push_value;
            tag_mem[wr_ptr_reg]   <= push_tag;
        end
    end

endmodule

[design/line_buffer_conv2d.sv]
// Streaming 5x5 sliding-window correlation over a raster-order pixel stream, with
// coefficient writes sharing the input channel. One input word is taken per clock
// when the output side keeps up. A result passes through the line-store read, the
// window update, the multiply, row-sum and row-total registers, and the output
// queue. The rate is set by the line store, one memory of MAX_WIDTH words holding
// the four previous rows of a column, read once and written once per clock; a
// read of the column being written in that cycle is forwarded. Input stall rises
// while eight results are queued or in flight. The line store needs no clearing
// pass: a fill mark tracks the columns written since reset and the unwritten ones
// read as zero, so the block is ready straight after reset.
module line_buffer_conv2d (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic signed [lbc_pkg::PIX_W-1:0]      pixel_value,
    input  logic [lbc_pkg::COEF_IDX_W-1:0]        coef_row,
    input  logic [lbc_pkg::COEF_IDX_W-1:0]        coef_col,
    input  logic signed [lbc_pkg::PIX_W-1:0]      coef_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [lbc_pkg::ACC_W-1:0]      output_value,
    output logic                                  last_of_row,
    output logic                                  last_of_frame,
    input  logic                                  cfg_write_en,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lbc_pkg::CFG_W-1:0]             cfg_data
);

    localparam int K = lbc_pkg::KERNEL_SIZE;
    localparam int L = lbc_pkg::LINES;
    localparam int P = lbc_pkg::PIX_W;

    // configuration
    logic [lbc_pkg::WIDTH_W-1:0]  width_reg;
    logic [lbc_pkg::HEIGHT_W-1:0] height_reg;
    logic [lbc_pkg::W_W-1:0]      w_eff;
    logic [lbc_pkg::HEIGHT_W-1:0] h_eff;

    // counters
    logic [lbc_pkg::COL_W-1:0]    col_reg;
    logic [lbc_pkg::HEIGHT_W-1:0] row_reg;
    logic                         row_end;
    logic                         frame_end;
    logic                         emit;

    logic in_accept;
    logic pix_accept;

    // line store
    logic [L*P-1:0]             line_mem [lbc_pkg::MAX_WIDTH];
    logic [L*P-1:0]             rd_data_reg;
    logic                       rd_ok_reg;
    logic                       byp_hit_reg;
    logic [L*P-1:0]             byp_data_reg;
    logic [lbc_pkg::HW_W-1:0]   fill_reg;
    logic [L*P-1:0]             old_word;
    logic [L*P-1:0]             new_word;
    logic                       mem_we;

    // window stage
    logic                          s1_valid_reg;
    logic                          s1_coef_reg;
    logic                          s1_emit_reg;
    lbc_pkg::tag_t                 s1_tag_reg;
    lbc_pkg::pix_t                 s1_pix_reg;
    logic [lbc_pkg::COL_W-1:0]     s1_col_reg;
    logic [lbc_pkg::COEF_IDX_W-1:0] s1_crow_reg;
    logic [lbc_pkg::COEF_IDX_W-1:0] s1_ccol_reg;
    lbc_pkg::pix_t                 s1_cval_reg;
    lbc_pkg::pix_t                 column [K];

    lbc_pkg::win_t window_reg;
    lbc_pkg::win_t coef_reg;
    logic          win_valid_reg;
    lbc_pkg::tag_t win_tag_reg;

    // result path
    logic          dot_valid;
    lbc_pkg::tag_t dot_tag;
    lbc_pkg::acc_t dot_value;
    lbc_pkg::tag_t head_tag;
    logic          out_accept;

    logic [lbc_pkg::FIFO_AW:0] pend_reg;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = lbc_pkg::W_W'(1);
        end
        else if (lbc_pkg::W_W'(width_reg) > lbc_pkg::W_W'(lbc_pkg::MAX_WIDTH))
        begin
            w_eff = lbc_pkg::W_W'(lbc_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = lbc_pkg::W_W'(width_reg);
        end
        h_eff = (height_reg == '0) ? lbc_pkg::HEIGHT_W'(1) : height_reg;
    end

    assign in_stall   = (pend_reg >= (lbc_pkg::FIFO_AW + 1)'(lbc_pkg::FIFO_DEPTH));
    assign in_accept  = in_valid && !in_stall;
    assign pix_accept = in_accept && (action == lbc_pkg::ACT_PIXEL);

    assign row_end   = (lbc_pkg::W_W'(col_reg) + lbc_pkg::W_W'(1)) >= w_eff;
    assign frame_end = row_end &&
        (({1'b0, row_reg} + (lbc_pkg::HEIGHT_W + 1)'(1)) >= {1'b0, h_eff});
    assign emit = (row_reg >= lbc_pkg::HEIGHT_W'(K - 1)) &&
                  (col_reg >= lbc_pkg::COL_W'(K - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lbc_pkg::WIDTH_W'(1024);
            height_reg <= lbc_pkg::HEIGHT_W'(1024);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                lbc_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[lbc_pkg::WIDTH_W-1:0];
                lbc_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[lbc_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_accept)
        begin
            if (row_end)
            begin
                col_reg <= '0;
                row_reg <= frame_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // line store: read at accept, written back in the following cycle
    assign mem_we = s1_valid_reg && !s1_coef_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[s1_col_reg] <= new_word;
        end
        if (pix_accept)
        begin
            rd_data_reg <= line_mem[col_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            rd_ok_reg   <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            // columns are written in order from zero, so a mark covers them all
            if (mem_we && ({1'b0, s1_col_reg} >= fill_reg))
            begin
                fill_reg <= {1'b0, s1_col_reg} + lbc_pkg::HW_W'(1);
            end
            if (pix_accept)
            begin
                rd_ok_reg   <= {1'b0, col_reg} < fill_reg;
                byp_hit_reg <= mem_we && (s1_col_reg == col_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            byp_data_reg <= new_word;
        end
    end

    always_comb
    begin
        if (byp_hit_reg)
        begin
            old_word = byp_data_reg;
        end
        else if (rd_ok_reg)
        begin
            old_word = rd_data_reg;
        end
        else
        begin
            old_word = '0;
        end
        for (int m = 0; m < L; m++)
        begin
            column[m] = old_word[m*P +: P];
        end
        column[L] = s1_pix_reg;
        for (int m = 0; m < L; m++)
        begin
            new_word[m*P +: P] = column[m+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_coef_reg  <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            s1_coef_reg  <= (action == lbc_pkg::ACT_COEF);
            s1_emit_reg  <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg  <= '{last_of_row: row_end, last_of_frame: frame_end};
        s1_pix_reg  <= pixel_value;
        s1_col_reg  <= col_reg;
        s1_crow_reg <= coef_row;
        s1_ccol_reg <= coef_col;
        s1_cval_reg <= coef_value;
        win_tag_reg <= s1_tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
            for (int m = 0; m < K; m++)
            begin
                for (int n = 0; n < K; n++)
                begin
                    window_reg[m][n] <= '0;
                    coef_reg[m][n]   <= '0;
                end
            end
        end
        else
        begin
            win_valid_reg <= s1_valid_reg && !s1_coef_reg && s1_emit_reg;
            if (s1_valid_reg && !s1_coef_reg)
            begin
                for (int m = 0; m < K; m++)
                begin
                    for (int n = 0; n < K - 1; n++)
                    begin
                        window_reg[m][n] <= window_reg[m][n+1];
                    end
                    window_reg[m][K-1] <= column[m];
                end
            end
            if (s1_valid_reg && s1_coef_reg)
            begin
                // out-of-range kernel positions match nothing
                for (int m = 0; m < K; m++)
                begin
                    for (int n = 0; n < K; n++)
                    begin
                        if (s1_crow_reg == lbc_pkg::COEF_IDX_W'(m) &&
                            s1_ccol_reg == lbc_pkg::COEF_IDX_W'(n))
                        begin
                            coef_reg[m][n] <= s1_cval_reg;
                        end
                    end
                end
            end
        end
    end

    lbc_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (win_valid_reg),
        .in_tag    (win_tag_reg),
        .window    (window_reg),
        .coef      (coef_reg),
        .out_valid (dot_valid),
        .out_tag   (dot_tag),
        .out_value (dot_value)
    );

    lbc_ofifo u_ofifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (dot_valid),
        .push_tag   (dot_tag),
        .push_value (dot_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_tag    (head_tag),
        .out_value  (output_value)
    );

    assign last_of_row   = head_tag.last_of_row;
    assign last_of_frame = head_tag.last_of_frame;
    assign out_accept    = out_valid && !out_stall;

    // results in flight or queued; keeps the output queue from overflowing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if ((pix_accept && emit) && !out_accept)
        begin
            pend_reg <= pend_reg + 1'b1;
        end
        else if (out_accept && !(pix_accept && emit))
        begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= (lbc_pkg::FIFO_AW + 1)'(lbc_pkg::FIFO_DEPTH))
        else $error("result credit count above queue depth");

    a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != '0))
        else $error("result shown with no credit outstanding");

    a_pixel_reaches_window: assert property (@(posedge clk) disable iff (!rst_n)
        pix_accept |=> (s1_valid_reg && !s1_coef_reg))
        else $error("accepted pixel missing from window stage");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= lbc_pkg::HW_W'(lbc_pkg::MAX_WIDTH))
        else $error("line store fill mark beyond depth");

    a_emit_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_coef_reg && s1_emit_reg) |=> ##3 dot_valid)
        else $error("window result lost in adder tree");
`endif

endmodule
